// ----- sv/rufp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rufp_pkg
// Types and constants shared by the radar UART frame parser modules.
// ----------------------------------------------------------------------------
package rufp_pkg;

  typedef enum logic [1:0] {
    KIND_PRESENCE = 2'd0,
    KIND_CONFIG   = 2'd1,
    KIND_SHORT    = 2'd2,
    KIND_BADHDR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       report_kind;
    logic [7:0]  movement_state;
    logic [7:0]  move_distance;
    logic [7:0]  move_energy;
    logic [7:0]  static_distance;
    logic [7:0]  static_energy;
    logic [7:0]  max_move_gate;
    logic [7:0]  max_static_gate;
    logic [7:0]  move_sens;
    logic [7:0]  still_sens;
    logic [15:0] unattended_seconds;
  } report_t;

  localparam logic [31:0] CFG_TRAILER  = 32'h0403_0201;
  localparam logic [31:0] CFG_HEADER   = 32'hFDFC_FBFA;
  localparam logic [31:0] PRES_TRAILER = 32'hF8F7_F6F5;
  localparam logic [31:0] PRES_HEADER  = 32'hF4F3_F2F1;

  localparam int unsigned CFG_MIN_LEN  = 23;
  localparam int unsigned CFG_LEN      = 34;
  localparam int unsigned PRES_MIN_LEN = 11;
  localparam int unsigned PRES_LEN     = 21;
  localparam int unsigned TRAILER_LEN  = 4;

  localparam logic [15:0] THROTTLE_RESET = 16'd1000;

  // bytes of the frame that are ever looked at, captured as they arrive
  localparam int unsigned NUM_CAP = 13;
  localparam int unsigned CAP_H0  = 0;
  localparam int unsigned CAP_H1  = 1;
  localparam int unsigned CAP_H2  = 2;
  localparam int unsigned CAP_H3  = 3;
  localparam int unsigned CAP_B8  = 4;
  localparam int unsigned CAP_B9  = 5;
  localparam int unsigned CAP_B11 = 6;
  localparam int unsigned CAP_B12 = 7;
  localparam int unsigned CAP_B13 = 8;
  localparam int unsigned CAP_B14 = 9;
  localparam int unsigned CAP_B23 = 10;
  localparam int unsigned CAP_B28 = 11;
  localparam int unsigned CAP_B29 = 12;

  localparam int unsigned CAP_POS [NUM_CAP] = '{0, 1, 2, 3, 8, 9, 11, 12, 13, 14, 23, 28, 29};

endpackage

// ----- sv/rufp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rufp_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module rufp_in_stage
  import rufp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_take,
  output item_t item
);

  logic valid;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- sv/rufp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rufp_parser
// Frame state and trailer decode: fill position, last four bytes, captured
// header and field bytes, presence throttle timestamp.
// ----------------------------------------------------------------------------
module rufp_parser
  import rufp_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] throttle_ms,
  output logic        res_valid,
  output report_t     res
);

  localparam int unsigned POS_W = $clog2(STORE_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(STORE_BYTES - 1);

  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      tail, tail_next;
  logic [31:0]      last_ms, last_ms_next;
  logic [7:0]       cap      [NUM_CAP];
  logic [7:0]       cap_next [NUM_CAP];

  logic             store;
  logic [POS_W-1:0] len;
  logic [31:0]      header;
  logic [31:0]      elapsed;
  logic             check;
  report_t          rep;
  logic             hit;

  assign store     = (pos < POS_LAST);
  assign len       = pos + POS_W'(1);
  assign tail_next = store ? {tail[23:0], item.rx_byte} : tail;

  // current byte bypasses into the captured copies
  for (genvar k = 0; k < NUM_CAP; k++) begin : g_cap
    assign cap_next[k] = (store && pos == POS_W'(CAP_POS[k])) ? item.rx_byte : cap[k];
  end

  assign header  = {cap_next[CAP_H0], cap_next[CAP_H1], cap_next[CAP_H2], cap_next[CAP_H3]};
  assign elapsed = item.now_ms - last_ms;
  assign check   = store && (len >= POS_W'(TRAILER_LEN));

  always_comb begin
    rep          = '0;
    hit          = 1'b0;
    last_ms_next = last_ms;
    pos_next     = store ? len : '0;
    if (check && tail_next == CFG_TRAILER) begin
      pos_next = '0;
      if (len >= POS_W'(CFG_MIN_LEN)) begin
        if (header != CFG_HEADER) begin
          hit             = 1'b1;
          rep.report_kind = KIND_BADHDR;
        end else if (len == POS_W'(CFG_LEN)) begin
          hit                    = 1'b1;
          rep.report_kind        = KIND_CONFIG;
          rep.max_move_gate      = cap_next[CAP_B12];
          rep.max_static_gate    = cap_next[CAP_B13];
          rep.move_sens          = cap_next[CAP_B14];
          rep.still_sens         = cap_next[CAP_B23];
          rep.unattended_seconds = {cap_next[CAP_B29], cap_next[CAP_B28]};
        end
      end
    end else if (check && tail_next == PRES_TRAILER) begin
      pos_next = '0;
      if (header == PRES_HEADER) begin
        if (len < POS_W'(PRES_MIN_LEN)) begin
          hit             = 1'b1;
          rep.report_kind = KIND_SHORT;
        end else if (elapsed >= {16'd0, throttle_ms}) begin
          last_ms_next = item.now_ms;
          if (len == POS_W'(PRES_LEN)) begin
            hit                 = 1'b1;
            rep.report_kind     = KIND_PRESENCE;
            rep.movement_state  = cap_next[CAP_B8];
            rep.move_distance   = cap_next[CAP_B9];
            rep.move_energy     = cap_next[CAP_B11];
            rep.static_distance = cap_next[CAP_B12];
            rep.static_energy   = cap_next[CAP_B14];
          end
        end
      end
    end
  end

  assign res_valid = fire && hit;
  assign res       = rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      last_ms <= '0;
    end else if (fire) begin
      pos     <= pos_next;
      last_ms <= last_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tail <= tail_next;
      for (int k = 0; k < NUM_CAP; k++) begin
        cap[k] <= cap_next[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("fill position beyond store");
  a_empty_after_report: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> pos == '0)
    else $error("store not emptied after a report");
  a_presence_stamp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.report_kind == KIND_PRESENCE) |=> last_ms == $past(item.now_ms))
    else $error("presence report without timestamp update");
`endif

endmodule

// ----- sv/rufp_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rufp_out_reg
// Result register: holds one report until the receiver takes it.
// ----------------------------------------------------------------------------
module rufp_out_reg
  import rufp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  report_t res,
  output logic    load_ok,
  output logic    out_valid,
  input  logic    out_ready,
  output report_t out
);

  logic valid;

  assign load_ok   = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ok) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res_valid) begin
      out <= res;
    end
  end

endmodule

// ----- sv/radar_uart_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_uart_frame_parser_unit
// Parses radar UART frames byte by byte and emits config, presence, short-frame
// and bad-header reports. s_* : one received byte with its millisecond timestamp per transfer.
// m_* : at most one report per byte; m_tuser carries the report kind.
// cfg_* : writes throttle_ms (minimum ms between presence frames).
// The byte that ends a frame is held in the input register; its report is then
// registered in the result register. One byte per cycle while no report is held;
// each register holds one transfer, so a byte is taken while a report waits.
// While the receiver stalls with a report held, the next byte waits in the
// input register and s_tready drops until the held report is taken.
// Reset: store empty, throttle timestamp 0, throttle_ms 1000.
// ----------------------------------------------------------------------------
module radar_uart_frame_parser_unit
  import rufp_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // rx_byte, now_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // movement_state, move_distance, move_energy,
                                 // static_distance, static_energy, max_move_gate,
                                 // max_static_gate, move_sens,
                                 // still_sens, unattended_seconds
  output logic [1:0]  m_tuser,   // report_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] throttle_ms;
  item_t       in_item, item;
  logic        item_valid, fire, load_ok, res_valid;
  report_t     res, out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_ms <= THROTTLE_RESET;
    end else if (cfg_valid) begin
      throttle_ms <= cfg_data;
    end
  end

  assign in_item.rx_byte = s_tdata[7:0];
  assign in_item.now_ms  = s_tdata[39:8];
  assign fire            = item_valid && load_ok;

  rufp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (load_ok),
    .item       (item)
  );

  rufp_parser #(
    .STORE_BYTES (STORE_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .throttle_ms (throttle_ms),
    .res_valid   (res_valid),
    .res         (res)
  );

  rufp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out       (out)
  );

  assign m_tuser = out.report_kind;
  assign m_tdata = {out.unattended_seconds, out.still_sens, out.move_sens,
                    out.max_static_gate, out.max_move_gate, out.static_energy,
                    out.static_distance, out.move_energy, out.move_distance,
                    out.movement_state};

endmodule
